// File: rtl/pmg_pkg.sv
package pmg_pkg;

    // Sample format
    localparam int SAMPLE_BITS = 16;

    // BT.601 lightness weights in Q0.16
    localparam logic [31:0] LUMA_R = 32'd19588;
    localparam logic [31:0] LUMA_G = 32'd38470;
    localparam logic [31:0] LUMA_B = 32'd7471;
    localparam logic [32:0] LUMA_ROUND = 33'd32768;

    // Front to back queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    // Divider shapes
    localparam int HUE_QW = 8;
    localparam int HUE_DW = 9;
    localparam int WGT_QW = 16;
    localparam int WGT_DW = 7;

    typedef enum logic [1:0] {
        MODE_BINARY = 2'd0,
        MODE_RANGE  = 2'd1,
        MODE_LIGHT  = 2'd2,
        MODE_HUE    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_MASK_MODE     = 3'd0,
        REG_LOWER_LIMIT   = 3'd1,
        REG_UPPER_LIMIT   = 3'd2,
        REG_RANGE_FUZZ    = 3'd3,
        REG_RANGE_OPTIONS = 3'd4,
        REG_HUE_BAND      = 3'd5,
        REG_HUE_FUZZ      = 3'd6,
        REG_WHOLE_IMAGE   = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        KIND_ZERO = 2'd0,
        KIND_FULL = 2'd1,
        KIND_DIV  = 2'd2
    } kind_t;

    typedef struct packed {
        mode_t       mask_mode;
        logic [6:0]  lower_limit;
        logic [6:0]  upper_limit;
        logic [6:0]  range_fuzz;
        logic [1:0]  range_options;
        logic [2:0]  hue_band;
        logic [5:0]  hue_fuzz;
        logic        whole_image;
    } cfg_t;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic        mono;
        logic [15:0] shape;
        logic [7:0]  r8;
        logic [7:0]  g8;
        logic [7:0]  b8;
    } q_entry_t;

    typedef struct packed {
        logic [15:0] v;
        logic [15:0] shape;
        logic        hue_ok;
    } hd_side_t;

    typedef struct packed {
        logic [15:0] v;
        logic [15:0] shape;
        kind_t       kind;
    } wd_side_t;

    typedef struct packed {
        logic [8:0] e0;
        logic [8:0] e1;
        logic [8:0] e2;
        logic [8:0] e3;
    } edges_t;

    // Band edges in degrees: two intervals, equal except for red
    function automatic edges_t band_edges(input logic [2:0] band);
        edges_t e;
        case (band)
            3'd0:    e = '{9'd0,   9'd15,  9'd345, 9'd360};
            3'd1:    e = '{9'd15,  9'd45,  9'd15,  9'd45};
            3'd2:    e = '{9'd45,  9'd75,  9'd45,  9'd75};
            3'd3:    e = '{9'd75,  9'd165, 9'd75,  9'd165};
            3'd4:    e = '{9'd165, 9'd195, 9'd165, 9'd195};
            3'd5:    e = '{9'd195, 9'd255, 9'd195, 9'd255};
            3'd6:    e = '{9'd255, 9'd300, 9'd255, 9'd300};
            default: e = '{9'd300, 9'd345, 9'd300, 9'd345};
        endcase
        return e;
    endfunction

    // Circular distance between two angles in degrees
    function automatic logic [8:0] edge_dist(input logic [8:0] h, input logic [8:0] e);
        logic [8:0] d;
        logic [8:0] dr;
        d  = (h > e) ? h - e : e - h;
        dr = 9'd360 - d;
        return (dr < d) ? dr : d;
    endfunction

    function automatic logic [6:0] sat100(input logic [6:0] x);
        return (x > 7'd100) ? 7'd100 : x;
    endfunction

endpackage

// File: rtl/pmg_front.sv
// Prepares the queue entry for an incoming pixel: 8-bit channel values for the hue path
module pmg_front (
    input  logic [15:0]         s_red,
    input  logic [15:0]         s_green,
    input  logic [15:0]         s_blue,
    input  logic                s_mono_pixel,
    input  logic [15:0]         s_shape_mask,
    output pmg_pkg::q_entry_t   entry
);

    logic [23:0] r255;
    logic [23:0] g255;
    logic [23:0] b255;

    // x * 255 as (x << 8) - x, then keep the integer part
    assign r255 = {s_red, 8'b0} - {8'b0, s_red};
    assign g255 = {s_green, 8'b0} - {8'b0, s_green};
    assign b255 = {s_blue, 8'b0} - {8'b0, s_blue};

    always_comb begin
        entry.red   = s_red;
        entry.green = s_green;
        entry.blue  = s_blue;
        entry.mono  = s_mono_pixel;
        entry.shape = s_shape_mask;
        entry.r8    = r255[23:16];
        entry.g8    = g255[23:16];
        entry.b8    = b255[23:16];
    end

endmodule

// File: rtl/pmg_queue.sv
// Short queue between front and back
module pmg_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  pmg_pkg::q_entry_t   push_data,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output pmg_pkg::q_entry_t   head
);

    localparam int PW = pmg_pkg::QUEUE_PTR_W;

    pmg_pkg::q_entry_t mem [pmg_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   count_reg;
    logic [PW:0]   count_next;

    assign full      = (count_reg == (PW+1)'(pmg_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (PW+1)'(pmg_pkg::QUEUE_DEPTH))
        else $error("queue fill count beyond depth");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full && !pop))
        else $error("queue written while full");

endmodule

// File: rtl/pmg_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// The upper DW bits of the numerator must be below the divisor.
module pmg_div #(
    parameter int QW = 16,
    parameter int DW = 7,
    parameter int SW = 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [QW+DW-1:0]    in_num,
    input  logic [DW-1:0]       in_den,
    input  logic [SW-1:0]       in_side,
    output logic                out_valid,
    output logic [QW-1:0]       out_quot,
    output logic [SW-1:0]       out_side
);

    logic [DW-1:0] rem_reg  [QW];
    logic [QW-1:0] work_reg [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [SW-1:0] side_reg [QW];
    logic [QW-1:0] vld_reg;

    logic [DW-1:0] rem_src  [QW];
    logic [QW-1:0] work_src [QW];
    logic [DW-1:0] den_src  [QW];
    logic [SW-1:0] side_src [QW];
    logic [QW-1:0] vld_src;
    logic [DW-1:0] rem_next  [QW];
    logic [QW-1:0] work_next [QW];
    logic [DW:0]   trial     [QW];
    logic [DW:0]   diff      [QW];

    // Stage sources
    always_comb begin
        rem_src[0]  = in_num[QW+DW-1:QW];
        work_src[0] = in_num[QW-1:0];
        den_src[0]  = in_den;
        side_src[0] = in_side;
        vld_src[0]  = in_valid;
        for (int i = 1; i < QW; i++) begin
            rem_src[i]  = rem_reg[i-1];
            work_src[i] = work_reg[i-1];
            den_src[i]  = den_reg[i-1];
            side_src[i] = side_reg[i-1];
            vld_src[i]  = vld_reg[i-1];
        end
    end

    // One trial subtraction per stage
    always_comb begin
        for (int i = 0; i < QW; i++) begin
            trial[i] = {rem_src[i], work_src[i][QW-1]};
            diff[i]  = trial[i] - {1'b0, den_src[i]};
            if (trial[i] >= {1'b0, den_src[i]}) begin
                rem_next[i]  = diff[i][DW-1:0];
                work_next[i] = {work_src[i][QW-2:0], 1'b1};
            end else begin
                rem_next[i]  = trial[i][DW-1:0];
                work_next[i] = {work_src[i][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_src;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < QW; i++) begin
                rem_reg[i]  <= rem_next[i];
                work_reg[i] <= work_next[i];
                den_reg[i]  <= den_src[i];
                side_reg[i] <= side_src[i];
            end
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign out_quot  = work_reg[QW-1];
    assign out_side  = side_reg[QW-1];

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("divider stages moved while stalled");

endmodule

// File: rtl/pmg_back.sv
// Back end: lightness, hue angle, weights and mode selection
module pmg_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  pmg_pkg::cfg_t       cfg,
    input  logic                q_valid,
    input  pmg_pkg::q_entry_t   q_data,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [15:0]         m_mask_value
);

    logic en;

    // Stage 1 registers
    logic        v1_reg;
    logic [31:0] pr_reg;
    logic [31:0] pg_reg;
    logic [31:0] pb_reg;
    logic [15:0] r1_reg;
    logic        mono1_reg;
    logic [15:0] shape1_reg;
    logic [15:0] x1_reg;
    logic [7:0]  d1_reg;
    logic        hok1_reg;

    // Stage 1 combinational
    logic [7:0]         mx;
    logic [7:0]         mn;
    logic [7:0]         d;
    logic [8:0]         sum;
    logic [8:0]         den_s;
    logic signed [17:0] rs;
    logic signed [17:0] gs;
    logic signed [17:0] bs;
    logic signed [17:0] ds;
    logic signed [17:0] x_s;
    logic [11:0]        d10;
    logic               hue_ok;

    // Hue divider
    logic [32:0]              lsum;
    logic [15:0]              v2;
    pmg_pkg::hd_side_t        hd_in_side;
    pmg_pkg::hd_side_t        hd_out_side;
    logic [pmg_pkg::HUE_QW+pmg_pkg::HUE_DW-1:0] hd_num;
    logic [pmg_pkg::HUE_DW-1:0] hd_den;
    logic                     hd_valid;
    logic [pmg_pkg::HUE_QW-1:0] hd_quot;

    // Weight set-up
    pmg_pkg::edges_t    edg;
    logic [8:0]         hdeg;
    logic               inband;
    logic [8:0]         edge_gap;
    logic [8:0]         dist_a;
    logic [8:0]         dist_b;
    logic [6:0]         lo_lim;
    logic [6:0]         up_lim;
    logic [6:0]         fr;
    logic signed [24:0] xq;
    logic signed [24:0] lq;
    logic signed [24:0] uq;
    logic signed [24:0] fq;
    logic signed [24:0] num_lo;
    logic signed [24:0] num_up;
    logic [6:0]         hf_diff;
    pmg_pkg::wd_side_t  wd_in_side;
    pmg_pkg::wd_side_t  wd_out_side;
    logic [pmg_pkg::WGT_QW+pmg_pkg::WGT_DW-1:0] wd_num;
    logic [pmg_pkg::WGT_DW-1:0] wd_den;
    logic                     wd_valid;
    logic [pmg_pkg::WGT_QW-1:0] wd_quot;

    // Stage 4 and 5
    logic        v4_reg;
    logic [16:0] w4_reg;
    logic [15:0] lv4_reg;
    logic [15:0] shape4_reg;
    logic [16:0] w4_next;
    logic [16:0] wsel;
    logic [32:0] scr_prod;
    logic        v5_reg;
    logic [16:0] w5_reg;
    logic [15:0] lv5_reg;
    logic [15:0] shape5_reg;
    logic [16:0] w5_next;
    logic [16:0] base4;
    logic [33:0] shp_prod;

    // Output
    logic        m_valid_reg;
    logic [15:0] m_mask_value_reg;
    logic [16:0] res;
    logic        base_set;

    assign en    = !m_valid_reg || m_ready;
    assign q_pop = en && q_valid;

    // Stage 1: lightness products and hue preparation
    always_comb begin
        mx = q_data.r8;
        if (q_data.g8 > mx) mx = q_data.g8;
        if (q_data.b8 > mx) mx = q_data.b8;
        mn = q_data.r8;
        if (q_data.g8 < mn) mn = q_data.g8;
        if (q_data.b8 < mn) mn = q_data.b8;
        d     = mx - mn;
        sum   = {1'b0, mx} + {1'b0, mn};
        den_s = (sum < 9'd255) ? sum : 9'd510 - sum;
        rs    = $signed({10'b0, q_data.r8});
        gs    = $signed({10'b0, q_data.g8});
        bs    = $signed({10'b0, q_data.b8});
        ds    = $signed({10'b0, d});
        if (mx == q_data.r8) begin
            x_s = 18'sd30 * (gs - bs);
        end else if (mx == q_data.g8) begin
            x_s = 18'sd30 * (bs - rs) + 18'sd60 * ds;
        end else begin
            x_s = 18'sd30 * (rs - gs) + 18'sd120 * ds;
        end
        if (x_s < 0) begin
            x_s = x_s + 18'sd180 * ds;
        end
        // saturation of at least 0.1 of 255 means 10 d >= den
        d10    = 12'd10 * {4'b0, d};
        hue_ok = !q_data.mono && (d != 8'd0) && (d10 >= {3'b0, den_s});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pr_reg     <= {16'b0, q_data.red} * pmg_pkg::LUMA_R;
            pg_reg     <= {16'b0, q_data.green} * pmg_pkg::LUMA_G;
            pb_reg     <= {16'b0, q_data.blue} * pmg_pkg::LUMA_B;
            r1_reg     <= q_data.red;
            mono1_reg  <= q_data.mono;
            shape1_reg <= q_data.shape;
            x1_reg     <= x_s[15:0];
            d1_reg     <= d;
            hok1_reg   <= hue_ok;
        end
    end

    // Lightness sum and hue divider inputs: (2x + d) / 2d
    always_comb begin
        lsum = {1'b0, pr_reg} + {1'b0, pg_reg} + {1'b0, pb_reg} + pmg_pkg::LUMA_ROUND;
        v2   = mono1_reg ? r1_reg : lsum[31:16];
        hd_num = {x1_reg, 1'b0} + {9'b0, d1_reg};
        hd_den = {d1_reg, 1'b0};
        hd_in_side.v      = v2;
        hd_in_side.shape  = shape1_reg;
        hd_in_side.hue_ok = hok1_reg;
    end

    pmg_div #(
        .QW (pmg_pkg::HUE_QW),
        .DW (pmg_pkg::HUE_DW),
        .SW ($bits(pmg_pkg::hd_side_t))
    ) u_hue_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v1_reg),
        .in_num    (hd_num),
        .in_den    (hd_den),
        .in_side   (hd_in_side),
        .out_valid (hd_valid),
        .out_quot  (hd_quot),
        .out_side  (hd_out_side)
    );

    // Band test and range test, giving the weight divider operands
    always_comb begin
        edg    = pmg_pkg::band_edges(cfg.hue_band);
        hdeg   = {hd_quot, 1'b0};
        inband = ((hdeg >= edg.e0) && (hdeg <= edg.e1)) ||
                 ((hdeg >= edg.e2) && (hdeg <= edg.e3));
        dist_a = pmg_pkg::edge_dist(hdeg, edg.e0);
        dist_b = pmg_pkg::edge_dist(hdeg, edg.e1);
        if (dist_b < dist_a) dist_a = dist_b;
        edge_gap = pmg_pkg::edge_dist(hdeg, edg.e2);
        if (dist_a < edge_gap) edge_gap = dist_a;
        dist_b = pmg_pkg::edge_dist(hdeg, edg.e3);
        if (dist_b < edge_gap) edge_gap = dist_b;
        hf_diff = {1'b0, cfg.hue_fuzz} - edge_gap[6:0];

        lo_lim = pmg_pkg::sat100(cfg.lower_limit);
        up_lim = pmg_pkg::sat100(cfg.upper_limit);
        fr     = pmg_pkg::sat100(cfg.range_fuzz);
        xq     = $signed({2'b0, 23'({7'b0, hd_out_side.v} * 23'd100)});
        lq     = $signed({2'b0, lo_lim, 16'b0});
        uq     = $signed({2'b0, up_lim, 16'b0});
        fq     = $signed({2'b0, fr, 16'b0});
        num_lo = xq - lq + fq;
        num_up = uq + fq - xq;

        wd_in_side.v     = hd_out_side.v;
        wd_in_side.shape = hd_out_side.shape;
        wd_in_side.kind  = pmg_pkg::KIND_ZERO;
        wd_num = '0;
        wd_den = 7'd1;
        if (cfg.mask_mode == pmg_pkg::MODE_RANGE) begin
            wd_den = fr;
            if ((xq >= lq) && (xq <= uq)) begin
                wd_in_side.kind = pmg_pkg::KIND_FULL;
            end else if (fr == 7'd0) begin
                wd_in_side.kind = pmg_pkg::KIND_ZERO;
            end else if ((xq >= lq - fq) && (xq < lq)) begin
                wd_in_side.kind = pmg_pkg::KIND_DIV;
                wd_num = num_lo[22:0];
            end else if ((xq > uq) && (xq <= uq + fq)) begin
                wd_in_side.kind = pmg_pkg::KIND_DIV;
                wd_num = num_up[22:0];
            end
        end else begin
            wd_den = {1'b0, cfg.hue_fuzz};
            if (!hd_out_side.hue_ok) begin
                wd_in_side.kind = pmg_pkg::KIND_ZERO;
            end else if (inband) begin
                wd_in_side.kind = pmg_pkg::KIND_FULL;
            end else if (cfg.hue_fuzz == 6'd0) begin
                wd_in_side.kind = pmg_pkg::KIND_ZERO;
            end else if (edge_gap < {3'b0, cfg.hue_fuzz}) begin
                wd_in_side.kind = pmg_pkg::KIND_DIV;
                wd_num = {hf_diff, 16'b0};
            end
        end
    end

    pmg_div #(
        .QW (pmg_pkg::WGT_QW),
        .DW (pmg_pkg::WGT_DW),
        .SW ($bits(pmg_pkg::wd_side_t))
    ) u_wgt_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (hd_valid),
        .in_num    (wd_num),
        .in_den    (wd_den),
        .in_side   (wd_in_side),
        .out_valid (wd_valid),
        .out_quot  (wd_quot),
        .out_side  (wd_out_side)
    );

    // Stage 4: weight and optional screen by lightness
    always_comb begin
        case (wd_out_side.kind)
            pmg_pkg::KIND_FULL: wsel = 17'h10000;
            pmg_pkg::KIND_DIV:  wsel = {1'b0, wd_quot};
            default:            wsel = '0;
        endcase
        scr_prod = {16'b0, wsel} * {17'b0, wd_out_side.v};
        if ((cfg.mask_mode == pmg_pkg::MODE_RANGE) && cfg.range_options[0]) begin
            w4_next = scr_prod[32:16];
        end else begin
            w4_next = wsel;
        end
    end

    // Stage 5: times the shape coverage in range mode
    always_comb begin
        base4    = cfg.whole_image ? 17'h10000 : {1'b0, shape4_reg};
        shp_prod = {17'b0, w4_reg} * {17'b0, base4};
        if (cfg.mask_mode == pmg_pkg::MODE_RANGE) begin
            w5_next = shp_prod[32:16];
        end else begin
            w5_next = w4_reg;
        end
    end

    // Final mode selection and saturation
    always_comb begin
        base_set = cfg.whole_image || (shape5_reg != 16'd0);
        case (cfg.mask_mode)
            pmg_pkg::MODE_BINARY: res = {1'b0, shape5_reg};
            pmg_pkg::MODE_RANGE:  res = cfg.range_options[1] ? 17'h10000 - w5_reg : w5_reg;
            pmg_pkg::MODE_LIGHT:  res = base_set ? {1'b0, lv5_reg} : 17'd0;
            default:              res = base_set ? w5_reg : 17'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            w4_reg     <= w4_next;
            lv4_reg    <= wd_out_side.v;
            shape4_reg <= wd_out_side.shape;
            w5_reg     <= w5_next;
            lv5_reg    <= lv4_reg;
            shape5_reg <= shape4_reg;
            m_mask_value_reg <= res[16] ? 16'hFFFF : res[15:0];
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg      <= q_valid;
            v4_reg      <= wd_valid;
            v5_reg      <= v4_reg;
            m_valid_reg <= v5_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_mask_value = m_mask_value_reg;

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!en && v5_reg) |=> v5_reg)
        else $error("stage 5 transaction lost during stall");

    a_pop_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> v1_reg)
        else $error("popped transaction missing from stage 1");

endmodule

// File: rtl/pixel_mask_generator.sv
// Pipeline from input acceptance to result valid: queue, one product stage,
// 8 hue-angle divider stages, 16 weight divider stages, screen, shape and
// output stages; a 4-entry queue sits in front, and the pipelined dividers
// set the depth. Throughput: one pixel per clock unless m_ready stalls.
// Reset: synchronous active-low aresetn clears queue and valid bits; config
// registers return to zero except upper_limit, which resets to 100.
module pixel_mask_generator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_red,
    input  logic [15:0] s_green,
    input  logic [15:0] s_blue,
    input  logic        s_mono_pixel,
    input  logic [15:0] s_shape_mask,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_mask_value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    pmg_pkg::cfg_t     cfg_reg;
    pmg_pkg::q_entry_t front_entry;
    pmg_pkg::q_entry_t q_head;
    logic              q_full;
    logic              q_not_empty;
    logic              q_pop;
    logic              push;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign push      = s_valid && s_ready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mask_mode     <= pmg_pkg::MODE_BINARY;
            cfg_reg.lower_limit   <= 7'd0;
            cfg_reg.upper_limit   <= 7'd100;
            cfg_reg.range_fuzz    <= 7'd0;
            cfg_reg.range_options <= 2'd0;
            cfg_reg.hue_band      <= 3'd0;
            cfg_reg.hue_fuzz      <= 6'd0;
            cfg_reg.whole_image   <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (pmg_pkg::cfg_idx_t'(cfg_index))
                pmg_pkg::REG_MASK_MODE:     cfg_reg.mask_mode <= pmg_pkg::mode_t'(cfg_data[1:0]);
                pmg_pkg::REG_LOWER_LIMIT:   cfg_reg.lower_limit   <= cfg_data;
                pmg_pkg::REG_UPPER_LIMIT:   cfg_reg.upper_limit   <= cfg_data;
                pmg_pkg::REG_RANGE_FUZZ:    cfg_reg.range_fuzz    <= cfg_data;
                pmg_pkg::REG_RANGE_OPTIONS: cfg_reg.range_options <= cfg_data[1:0];
                pmg_pkg::REG_HUE_BAND:      cfg_reg.hue_band      <= cfg_data[2:0];
                pmg_pkg::REG_HUE_FUZZ:      cfg_reg.hue_fuzz      <= cfg_data[5:0];
                pmg_pkg::REG_WHOLE_IMAGE:   cfg_reg.whole_image   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    pmg_front u_front (
        .s_red        (s_red),
        .s_green      (s_green),
        .s_blue       (s_blue),
        .s_mono_pixel (s_mono_pixel),
        .s_shape_mask (s_shape_mask),
        .entry        (front_entry)
    );

    pmg_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (front_entry),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    pmg_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .q_valid      (q_not_empty),
        .q_data       (q_head),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_mask_value (m_mask_value)
    );

endmodule

// File: tb/sv/tb_top.sv
module tb_top;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_red = '0, s_green = '0, s_blue = '0, s_shape_mask = '0;
    logic        s_mono_pixel = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_mask_value;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [6:0]  cfg_data = '0;

    pixel_mask_generator u_dut (.*);

    localparam int PIPE_CYCLES = 40;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Shadow copy of the register file
    pmg_pkg::cfg_t shadow;
    logic [15:0] mask_q[$];
    int errors = 0;

    function automatic longint unsigned s100(longint unsigned x);
        return x > 100 ? 100 : x;
    endfunction

    function automatic longint unsigned luma(logic [15:0] r, logic [15:0] g,
                                             logic [15:0] b, logic mono);
        longint unsigned l;
        if (mono) return 64'(r);
        l = (64'd19588 * r + 64'd38470 * g + 64'd7471 * b + 64'd32768) >> 16;
        return l;
    endfunction

    function automatic longint unsigned ramp_weight(longint unsigned v);
        longint lq, uq, fq, x;
        longint unsigned f;
        x  = v * 100;
        lq = s100(shadow.lower_limit) * 65536;
        uq = s100(shadow.upper_limit) * 65536;
        f  = s100(shadow.range_fuzz);
        fq = f * 65536;
        if (x >= lq && x <= uq) return 65536;
        if (f == 0) return 0;
        if (x >= lq - fq && x < lq) return ((x - (lq - fq)) * 65536) / fq;
        if (x > uq && x <= uq + fq) return ((uq + fq - x) * 65536) / fq;
        return 0;
    endfunction

    function automatic longint unsigned circ_dist(longint unsigned h, longint unsigned e);
        longint unsigned d;
        d = h > e ? h - e : e - h;
        return (360 - d) < d ? 360 - d : d;
    endfunction

    function automatic longint unsigned band_w(longint unsigned h, longint unsigned lo,
                                               longint unsigned hi);
        longint unsigned d1, d2, dd, f;
        f = shadow.hue_fuzz;
        if (h >= lo && h <= hi) return 65536;
        if (f == 0) return 0;
        d1 = circ_dist(h, lo);
        d2 = circ_dist(h, hi);
        dd = d1 < d2 ? d1 : d2;
        if (dd < f) return ((f - dd) * 65536) / f;
        return 0;
    endfunction

    function automatic longint unsigned hue_key(logic [15:0] r, logic [15:0] g,
                                                logic [15:0] b, logic mono);
        longint r8, g8, b8, mx, mn, d, sum, den, x, s8, h8, w1, w2;
        longint unsigned lo0, hi0, lo1, hi1;
        if (mono) return 0;
        r8 = (longint'(r) * 255) >>> 16;
        g8 = (longint'(g) * 255) >>> 16;
        b8 = (longint'(b) * 255) >>> 16;
        mx = r8; if (g8 > mx) mx = g8; if (b8 > mx) mx = b8;
        mn = r8; if (g8 < mn) mn = g8; if (b8 < mn) mn = b8;
        d = mx - mn;
        if (d <= 0) return 0;
        sum = mx + mn;
        den = sum < 255 ? sum : 510 - sum;
        s8 = (510 * d + den) / (2 * den);
        if (s8 <= 25) return 0;
        if (mx == r8) x = 30 * (g8 - b8);
        else if (mx == g8) x = 30 * (b8 - r8) + 60 * d;
        else x = 30 * (r8 - g8) + 120 * d;
        if (x < 0) x += 180 * d;
        h8 = (2 * x + d) / (2 * d);
        // band edges in degrees; only red wraps
        case (shadow.hue_band)
            3'd0:    begin lo0 = 0;   hi0 = 15;  lo1 = 345; hi1 = 360; end
            3'd1:    begin lo0 = 15;  hi0 = 45;  lo1 = 15;  hi1 = 45;  end
            3'd2:    begin lo0 = 45;  hi0 = 75;  lo1 = 45;  hi1 = 75;  end
            3'd3:    begin lo0 = 75;  hi0 = 165; lo1 = 75;  hi1 = 165; end
            3'd4:    begin lo0 = 165; hi0 = 195; lo1 = 165; hi1 = 195; end
            3'd5:    begin lo0 = 195; hi0 = 255; lo1 = 195; hi1 = 255; end
            3'd6:    begin lo0 = 255; hi0 = 300; lo1 = 255; hi1 = 300; end
            default: begin lo0 = 300; hi0 = 345; lo1 = 300; hi1 = 345; end
        endcase
        w1 = band_w(2 * h8, lo0, hi0);
        w2 = band_w(2 * h8, lo1, hi1);
        return w1 > w2 ? w1 : w2;
    endfunction

    function automatic logic [15:0] mask_of(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                                            logic mono, logic [15:0] shp);
        longint unsigned base, res, v;
        base = shadow.whole_image ? 65536 : 64'(shp);
        case (shadow.mask_mode)
            pmg_pkg::MODE_BINARY: res = 64'(shp);
            pmg_pkg::MODE_RANGE: begin
                v = luma(r, g, b, mono);
                res = ramp_weight(v);
                if (shadow.range_options[0]) res = (res * v) >> 16;
                res = (res * base) >> 16;
                if (shadow.range_options[1]) res = 65536 - res;
            end
            pmg_pkg::MODE_LIGHT: res = base > 0 ? luma(r, g, b, mono) : 0;
            default:             res = base > 0 ? hue_key(r, g, b, mono) : 0;
        endcase
        if (res > 65535) res = 65535;
        return res[15:0];
    endfunction

    // Pixel transaction with optional hand-typed expectation
    typedef struct {
        logic [15:0] r, g, b, shp;
        logic        mono;
        bit          typed;
        logic [15:0] want;
    } pixel_row_t;

    task automatic send_pixel(pixel_row_t p);
        logic [15:0] e;
        e = p.typed ? p.want : mask_of(p.r, p.g, p.b, p.mono, p.shp);
        mask_q.push_back(e);
        s_red <= p.r; s_green <= p.g; s_blue <= p.b;
        s_mono_pixel <= p.mono; s_shape_mask <= p.shp;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic idle_gap();
        s_valid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge aclk);
    endtask

    task automatic write_reg(pmg_pkg::cfg_idx_t idx, logic [6:0] val);
        cfg_index <= idx; cfg_data <= val; cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            pmg_pkg::REG_MASK_MODE:     shadow.mask_mode = pmg_pkg::mode_t'(val[1:0]);
            pmg_pkg::REG_LOWER_LIMIT:   shadow.lower_limit = val;
            pmg_pkg::REG_UPPER_LIMIT:   shadow.upper_limit = val;
            pmg_pkg::REG_RANGE_FUZZ:    shadow.range_fuzz = val;
            pmg_pkg::REG_RANGE_OPTIONS: shadow.range_options = val[1:0];
            pmg_pkg::REG_HUE_BAND:      shadow.hue_band = val[2:0];
            pmg_pkg::REG_HUE_FUZZ:      shadow.hue_fuzz = val[5:0];
            default:                    shadow.whole_image = val[0];
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (mask_q.size() != 0) @(negedge aclk);
        repeat (PIPE_CYCLES) @(negedge aclk);
    endtask

    // Receiver stalls on a rotating pattern, with a stall-free stretch
    int unsigned stall_pat = 32'hB5C3_96E1;
    int unsigned rx_cycle = 0;
    always @(negedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if ((rx_cycle % 512) > 400) m_ready <= 1'b1;
        else m_ready <= stall_pat[rx_cycle % 32] | ($urandom_range(0, 3) == 0);
        if (rx_cycle % 97 == 0) stall_pat <= $urandom;
    end

    // Result checker
    always @(posedge aclk) begin
        logic [15:0] e;
        if (aresetn && m_valid && m_ready) begin
            if (mask_q.size() == 0) begin
                $error("unexpected mask_value transaction %0d", m_mask_value);
                errors++;
            end else begin
                e = mask_q.pop_front();
                if (m_mask_value !== e) begin
                    $error("mask_value expected %0d actual %0d", e, m_mask_value);
                    errors++;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    pixel_row_t dir_rows[] = '{
        // binary mode after reset: shape passes straight through
        '{16'h1234, 16'h0, 16'h0, 16'h0000, 1'b0, 1'b1, 16'h0000},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF},
        '{16'h0, 16'h0, 16'h0, 16'h8001, 1'b0, 1'b1, 16'h8001},
        '{16'hAAAA, 16'h5555, 16'hFFFF, 16'h5555, 1'b0, 1'b1, 16'h5555}
    };

    pixel_row_t p;
    int unsigned n_rand;

    task automatic rand_pixel(output pixel_row_t q);
        int k;
        k = $urandom_range(0, 9);
        q.r = 16'($urandom); q.g = 16'($urandom); q.b = 16'($urandom);
        q.shp = 16'($urandom);
        q.mono = $urandom_range(0, 3) == 0;
        q.typed = 0; q.want = '0;
        if (k == 0) begin q.g = q.r; q.b = q.r; end           // grey
        if (k == 1) q.shp = '0;
        if (k == 2) q.shp = 16'hFFFF;
        if (k == 3) begin q.r = 16'hFFFF; q.g = '0; end       // saturated hues
        if (k == 4) begin q.r = '0; q.g = 16'hFFFF; q.b = 16'h0; end
    endtask

    initial begin
        shadow = '{pmg_pkg::MODE_BINARY, 7'd0, 7'd100, 7'd0, 2'd0, 3'd0, 6'd0, 1'b0};
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: reset configuration, extremes of the fields
        foreach (dir_rows[i]) send_pixel(dir_rows[i]);
        drain();

        // directed: extreme settings across every mode
        for (int m = 0; m < 4; m++) begin
            write_reg(pmg_pkg::REG_MASK_MODE, 7'(m));
            write_reg(pmg_pkg::REG_LOWER_LIMIT, m[0] ? 7'd127 : 7'd0);
            write_reg(pmg_pkg::REG_UPPER_LIMIT, m[1] ? 7'd30 : 7'd127);
            write_reg(pmg_pkg::REG_RANGE_FUZZ, m == 1 ? 7'd127 : 7'd0);
            write_reg(pmg_pkg::REG_RANGE_OPTIONS, 7'(m));
            write_reg(pmg_pkg::REG_HUE_BAND, m == 3 ? 7'd7 : 7'd0);
            write_reg(pmg_pkg::REG_HUE_FUZZ, m == 3 ? 7'd63 : 7'd0);
            write_reg(pmg_pkg::REG_WHOLE_IMAGE, {6'b0, m[0]});
            p = '{16'hFFFF, 16'h0, 16'h0, 16'hFFFF, 1'b0, 1'b0, 16'h0}; send_pixel(p);
            p = '{16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0};       send_pixel(p);
            p = '{16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 1'b0, 1'b0, 16'h0};
            send_pixel(p);
            p = '{16'hC000, 16'h1000, 16'hF000, 16'hFFFF, 1'b1, 1'b0, 16'h0};
            send_pixel(p);
            drain();
        end

        // random phases, each under a fresh configuration
        n_rand = 0;
        while (n_rand < 850) begin
            write_reg(pmg_pkg::REG_MASK_MODE, 7'($urandom_range(0, 3)));
            write_reg(pmg_pkg::REG_LOWER_LIMIT,
                      7'($urandom_range(0, 7) == 0 ? $urandom_range(101, 127)
                                                   : $urandom_range(0, 100)));
            write_reg(pmg_pkg::REG_UPPER_LIMIT,
                      7'($urandom_range(0, 7) == 0 ? $urandom_range(101, 127)
                                                   : $urandom_range(0, 100)));
            write_reg(pmg_pkg::REG_RANGE_FUZZ,
                      7'($urandom_range(0, 4) == 0 ? 0 : $urandom_range(0, 127)));
            write_reg(pmg_pkg::REG_RANGE_OPTIONS, 7'($urandom_range(0, 3)));
            write_reg(pmg_pkg::REG_HUE_BAND, 7'($urandom_range(0, 7)));
            write_reg(pmg_pkg::REG_HUE_FUZZ, 7'($urandom_range(0, 63)));
            write_reg(pmg_pkg::REG_WHOLE_IMAGE, 7'($urandom_range(0, 1)));
            repeat ($urandom_range(40, 90)) begin
                rand_pixel(p);
                send_pixel(p);
                n_rand++;
                if ($urandom_range(0, 5) == 0) idle_gap();
            end
            drain();
        end

        if (errors == 0 && mask_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
